// File: src/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants of the banker safety checker.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int DEF_MAX_PROCESSES = 64;
  localparam int DEF_MAX_RESOURCES = 64;
  localparam int DEF_AMOUNT_WIDTH  = 16;

  localparam int CFG_W    = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CNT_W    = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [1:0] OP_LOAD_FREE = 2'd0;
  localparam logic [1:0] OP_LOAD_NEED = 2'd1;
  localparam logic [1:0] OP_GRANT     = 2'd2;
  localparam logic [1:0] OP_RESTART   = 2'd3;

  localparam logic REG_PROCESS_COUNT  = 1'b0;
  localparam logic REG_RESOURCE_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] PROCESS_COUNT_RST  = 7'd64;
  localparam logic [CFG_W-1:0] RESOURCE_COUNT_RST = 7'd64;

  typedef struct packed {
    logic [CFG_W-1:0] process_count;
    logic [CFG_W-1:0] resource_count;
  } cfg_t;

endpackage

// File: src/bsc_ram.sv
// ----------------------------------------------------------------------------
// bsc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bsc_ram #(
  parameter int ADDR_W = 6,
  parameter int WIDTH  = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/bsc_cfg.sv
// ----------------------------------------------------------------------------
// bsc_cfg
// APB register file holding the process and resource counts.
// ----------------------------------------------------------------------------
module bsc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bsc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output bsc_pkg::cfg_t                    cfg
);
  import bsc_pkg::*;

  logic [CFG_W-1:0] pc_r;
  logic [CFG_W-1:0] rc_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PROCESS_COUNT_RST;
      rc_r <= RESOURCE_COUNT_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_PROCESS_COUNT) begin
        pc_r <= pwdata[CFG_W-1:0];
      end else begin
        rc_r <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_PROCESS_COUNT) begin
      prdata = {{(32-CFG_W){1'b0}}, pc_r};
    end else begin
      prdata = {{(32-CFG_W){1'b0}}, rc_r};
    end
  end

  assign cfg.process_count  = pc_r;
  assign cfg.resource_count = rc_r;

endmodule

// File: src/bsc_ctrl.sv
// ----------------------------------------------------------------------------
// bsc_ctrl
// Table memories and the sequencer that runs grants and the safety check.
// ----------------------------------------------------------------------------
module bsc_ctrl #(
  parameter int MAX_PROCESSES = bsc_pkg::DEF_MAX_PROCESSES,
  parameter int MAX_RESOURCES = bsc_pkg::DEF_MAX_RESOURCES,
  parameter int AMOUNT_WIDTH  = bsc_pkg::DEF_AMOUNT_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bsc_pkg::cfg_t             cfg,
  input  logic                      start,
  input  logic [1:0]                opcode,
  input  logic [5:0]                process_index,
  input  logic [5:0]                resource_index,
  input  logic [15:0]               amount,
  output logic                      busy,
  output logic                      out_valid,
  output logic                      out_safe,
  output logic [bsc_pkg::CNT_W-1:0] out_grant_number,
  output logic [bsc_pkg::CNT_W-1:0] out_first_unsafe
);
  import bsc_pkg::*;

  localparam int AW   = AMOUNT_WIDTH;
  localparam int FW   = AW + 8;
  localparam int SW   = AW + 10;
  localparam int PW   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int RW   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int PCW  = $clog2(MAX_PROCESSES + 1);
  localparam int RCW  = $clog2(MAX_RESOURCES + 1);
  localparam int TW   = PW + RW;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RST_A = 5'd1;
  localparam logic [4:0] S_RST_B = 5'd2;
  localparam logic [4:0] S_G_RD  = 5'd3;
  localparam logic [4:0] S_G_EV  = 5'd4;
  localparam logic [4:0] S_SW_A  = 5'd5;
  localparam logic [4:0] S_SW_B  = 5'd6;
  localparam logic [4:0] S_MET_A = 5'd7;
  localparam logic [4:0] S_MET_B = 5'd8;
  localparam logic [4:0] S_RET_A = 5'd9;
  localparam logic [4:0] S_RET_B = 5'd10;
  localparam logic [4:0] S_CP_A  = 5'd11;
  localparam logic [4:0] S_CP_B  = 5'd12;
  localparam logic [4:0] S_FIT_I = 5'd13;
  localparam logic [4:0] S_FIT_A = 5'd14;
  localparam logic [4:0] S_FIT_B = 5'd15;
  localparam logic [4:0] S_UPD_A = 5'd16;
  localparam logic [4:0] S_UPD_B = 5'd17;
  localparam logic [4:0] S_ALL   = 5'd18;
  localparam logic [4:0] S_OUT   = 5'd19;

  logic [4:0]             state_r, state_nxt;
  logic [PW-1:0]          i_r, i_nxt;
  logic [RW-1:0]          j_r, j_nxt;
  logic [RW-1:0]          r_r, r_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       mark_r, mark_nxt;
  logic                   flag_r, flag_nxt;
  logic                   chg_r, chg_nxt;
  logic [MAX_PROCESSES-1:0] clean_r, clean_nxt;
  logic [MAX_PROCESSES-1:0] fin_r, fin_nxt;
  logic [MAX_PROCESSES-1:0] done_r, done_nxt;
  logic                   ov_r;
  logic                   safe_r;
  logic [CNT_W-1:0]       gn_r;
  logic [CNT_W-1:0]       fu_r;

  logic [PCW-1:0]         np;
  logic [RCW-1:0]         nr;
  logic [PW-1:0]          p_in;
  logic [RW-1:0]          r_in;
  logic [AW-1:0]          amt;
  logic                   ld_p_ok, ld_r_ok, grant_ok;
  logic                   last_nr, last_np, last_max;

  logic                   base_we, free_we, work_we, need_we, rem_we;
  logic [RW-1:0]          free_wa;
  logic [TW-1:0]          tab_wa;
  logic [FW-1:0]          free_wd, work_wd;
  logic [AW:0]            rem_wd;
  logic [AW-1:0]          base_rd, need_rd;
  logic [FW-1:0]          free_rd, work_rd;
  logic [AW:0]            rem_rd, remv;
  logic [SW-1:0]          work_ext, need_ext, rem_ext, upd_sum;
  logic [FW:0]            ret_sum;
  logic                   rem_gt_work;

  // count clamping: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (cfg.process_count == '0) begin
      np = PCW'(1);
    end else if (32'(cfg.process_count) > MAX_PROCESSES) begin
      np = PCW'(MAX_PROCESSES);
    end else begin
      np = PCW'(32'(cfg.process_count));
    end
    if (cfg.resource_count == '0) begin
      nr = RCW'(1);
    end else if (32'(cfg.resource_count) > MAX_RESOURCES) begin
      nr = RCW'(MAX_RESOURCES);
    end else begin
      nr = RCW'(32'(cfg.resource_count));
    end
  end

  assign p_in     = PW'(32'(process_index));
  assign r_in     = RW'(32'(resource_index));
  assign amt      = AW'(32'(amount));
  assign ld_p_ok  = 32'(process_index) < MAX_PROCESSES;
  assign ld_r_ok  = 32'(resource_index) < MAX_RESOURCES;
  assign grant_ok = (32'(process_index) < 32'(np)) && (32'(resource_index) < 32'(nr));
  assign last_nr  = (RCW'(j_r) == nr - RCW'(1));
  assign last_np  = (PCW'(i_r) == np - PCW'(1));
  assign last_max = (j_r == RW'(MAX_RESOURCES - 1));

  // a row still clean since restart reads its full need as remaining need
  assign remv        = clean_r[i_r] ? {1'b0, need_rd} : rem_rd;
  assign work_ext    = {2'b00, work_rd};
  assign need_ext    = SW'(need_rd);
  assign rem_ext     = {{(SW-AW-1){remv[AW]}}, remv};
  assign rem_gt_work = $signed(rem_ext) > $signed(work_ext);
  assign upd_sum     = work_ext + need_ext - rem_ext;
  assign ret_sum     = {1'b0, free_rd} + (FW+1)'(need_rd);

  bsc_ram #(.ADDR_W(RW), .WIDTH(AW)) u_base (
    .clk(clk), .we(base_we), .waddr(r_in), .wdata(amt),
    .raddr(j_r), .rdata(base_rd)
  );
  bsc_ram #(.ADDR_W(RW), .WIDTH(FW)) u_free (
    .clk(clk), .we(free_we), .waddr(free_wa), .wdata(free_wd),
    .raddr(j_r), .rdata(free_rd)
  );
  bsc_ram #(.ADDR_W(RW), .WIDTH(FW)) u_work (
    .clk(clk), .we(work_we), .waddr(j_r), .wdata(work_wd),
    .raddr(j_r), .rdata(work_rd)
  );
  bsc_ram #(.ADDR_W(TW), .WIDTH(AW)) u_need (
    .clk(clk), .we(need_we), .waddr({p_in, r_in}), .wdata(amt),
    .raddr({i_r, j_r}), .rdata(need_rd)
  );
  bsc_ram #(.ADDR_W(TW), .WIDTH(AW+1)) u_rem (
    .clk(clk), .we(rem_we), .waddr(tab_wa), .wdata(rem_wd),
    .raddr({i_r, j_r}), .rdata(rem_rd)
  );

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    r_nxt     = r_r;
    cnt_nxt   = cnt_r;
    mark_nxt  = mark_r;
    flag_nxt  = flag_r;
    chg_nxt   = chg_r;
    clean_nxt = clean_r;
    fin_nxt   = fin_r;
    done_nxt  = done_r;
    base_we   = 1'b0;
    free_we   = 1'b0;
    work_we   = 1'b0;
    need_we   = 1'b0;
    rem_we    = 1'b0;
    free_wa   = j_r;
    free_wd   = FW'(amt);
    work_wd   = free_rd;
    tab_wa    = {i_r, j_r};
    rem_wd    = {1'b0, amt};
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (opcode)
            OP_LOAD_FREE: begin
              if (ld_r_ok) begin
                base_we = 1'b1;
                free_we = 1'b1;
                free_wa = r_in;
              end
            end
            OP_LOAD_NEED: begin
              if (ld_p_ok && ld_r_ok) begin
                need_we = 1'b1;
                rem_we  = 1'b1;
                tab_wa  = {p_in, r_in};
              end
            end
            OP_GRANT: begin
              if (cnt_r != CNT_MAX) begin
                cnt_nxt = cnt_r + CNT_W'(1);
              end
              i_nxt = p_in;
              r_nxt = r_in;
              if (mark_r != '0) begin
                state_nxt = S_OUT;
              end else if (!grant_ok) begin
                j_nxt     = '0;
                state_nxt = S_CP_A;
              end else begin
                j_nxt     = r_in;
                state_nxt = S_G_RD;
              end
            end
            default: begin
              cnt_nxt   = '0;
              mark_nxt  = '0;
              fin_nxt   = '0;
              clean_nxt = '1;
              j_nxt     = '0;
              state_nxt = S_RST_A;
            end
          endcase
        end
      end
      S_RST_A: state_nxt = S_RST_B;
      S_RST_B: begin
        free_we = 1'b1;
        free_wd = FW'(base_rd);
        j_nxt   = j_r + RW'(1);
        state_nxt = last_max ? S_IDLE : S_RST_A;
      end
      S_G_RD: state_nxt = S_G_EV;
      S_G_EV: begin
        if (free_rd == '0) begin
          mark_nxt  = cnt_r;
          state_nxt = S_OUT;
        end else if (clean_r[i_r]) begin
          j_nxt     = '0;
          state_nxt = S_SW_A;
        end else begin
          free_we = 1'b1;
          free_wd = free_rd - FW'(1);
          rem_we  = 1'b1;
          rem_wd  = (rem_rd == {1'b1, {AW{1'b0}}}) ? rem_rd : rem_rd - (AW+1)'(1);
          j_nxt   = '0;
          if (fin_r[i_r]) begin
            state_nxt = S_CP_A;
          end else begin
            flag_nxt  = 1'b1;
            state_nxt = S_MET_A;
          end
        end
      end
      // copy the row's full need into its remaining need before first use
      S_SW_A: state_nxt = S_SW_B;
      S_SW_B: begin
        rem_we = 1'b1;
        rem_wd = {1'b0, need_rd};
        j_nxt  = j_r + RW'(1);
        if (last_max) begin
          clean_nxt[i_r] = 1'b0;
          j_nxt          = r_r;
          state_nxt      = S_G_RD;
        end else begin
          state_nxt = S_SW_A;
        end
      end
      S_MET_A: state_nxt = S_MET_B;
      S_MET_B: begin
        flag_nxt = flag_r & ~($signed(rem_rd) > $signed((AW+1)'(0)));
        j_nxt    = j_r + RW'(1);
        if (last_nr) begin
          j_nxt = '0;
          if (flag_nxt) begin
            fin_nxt[i_r] = 1'b1;
            state_nxt    = S_RET_A;
          end else begin
            state_nxt = S_CP_A;
          end
        end else begin
          state_nxt = S_MET_A;
        end
      end
      S_RET_A: state_nxt = S_RET_B;
      S_RET_B: begin
        free_we = 1'b1;
        free_wd = ret_sum[FW] ? {FW{1'b1}} : ret_sum[FW-1:0];
        j_nxt   = j_r + RW'(1);
        if (last_nr) begin
          j_nxt     = '0;
          state_nxt = S_CP_A;
        end else begin
          state_nxt = S_RET_A;
        end
      end
      S_CP_A: state_nxt = S_CP_B;
      S_CP_B: begin
        work_we = 1'b1;
        j_nxt   = j_r + RW'(1);
        if (last_nr) begin
          done_nxt  = fin_r;
          i_nxt     = '0;
          chg_nxt   = 1'b0;
          state_nxt = S_FIT_I;
        end else begin
          state_nxt = S_CP_A;
        end
      end
      S_FIT_I: begin
        if (done_r[i_r]) begin
          if (!last_np) begin
            i_nxt = i_r + PW'(1);
          end else if (chg_r) begin
            i_nxt   = '0;
            chg_nxt = 1'b0;
          end else begin
            i_nxt     = '0;
            state_nxt = S_ALL;
          end
        end else begin
          j_nxt     = '0;
          flag_nxt  = 1'b1;
          state_nxt = S_FIT_A;
        end
      end
      S_FIT_A: state_nxt = S_FIT_B;
      S_FIT_B: begin
        flag_nxt = flag_r & ~rem_gt_work;
        j_nxt    = j_r + RW'(1);
        if (!last_nr) begin
          state_nxt = S_FIT_A;
        end else if (flag_nxt) begin
          j_nxt     = '0;
          state_nxt = S_UPD_A;
        end else if (!last_np) begin
          i_nxt     = i_r + PW'(1);
          state_nxt = S_FIT_I;
        end else if (chg_r) begin
          i_nxt     = '0;
          chg_nxt   = 1'b0;
          state_nxt = S_FIT_I;
        end else begin
          i_nxt     = '0;
          state_nxt = S_ALL;
        end
      end
      S_UPD_A: state_nxt = S_UPD_B;
      S_UPD_B: begin
        work_we = 1'b1;
        work_wd = (upd_sum[SW-1:FW] != '0) ? {FW{1'b1}} : upd_sum[FW-1:0];
        j_nxt   = j_r + RW'(1);
        if (!last_nr) begin
          state_nxt = S_UPD_A;
        end else begin
          done_nxt[i_r] = 1'b1;
          state_nxt     = S_FIT_I;
          if (!last_np) begin
            i_nxt   = i_r + PW'(1);
            chg_nxt = 1'b1;
          end else begin
            // a process finished in this pass, so walk the processes again
            i_nxt   = '0;
            chg_nxt = 1'b0;
          end
        end
      end
      S_ALL: begin
        if (!done_r[i_r]) begin
          mark_nxt  = cnt_r;
          state_nxt = S_OUT;
        end else if (last_np) begin
          state_nxt = S_OUT;
        end else begin
          i_nxt = i_r + PW'(1);
        end
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      mark_r  <= '0;
      clean_r <= '1;
      fin_r   <= '0;
      done_r  <= '0;
      flag_r  <= 1'b0;
      chg_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      mark_r  <= mark_nxt;
      clean_r <= clean_nxt;
      fin_r   <= fin_nxt;
      done_r  <= done_nxt;
      flag_r  <= flag_nxt;
      chg_r   <= chg_nxt;
      ov_r    <= (state_r == S_OUT);
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    r_r <= r_nxt;
    if (state_r == S_OUT) begin
      safe_r <= (mark_r == '0);
      gn_r   <= cnt_r;
      fu_r   <= mark_r;
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_safe         = safe_r;
  assign out_grant_number = gn_r;
  assign out_first_unsafe = fu_r;

  a_strobe_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> ($past(state_r) == S_OUT))
    else $error("result strobe without a finished grant");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |=> !ov_r)
    else $error("result strobe longer than one cycle");

  a_safe_matches_mark: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (safe_r == (fu_r == '0)))
    else $error("safe flag disagrees with first unsafe grant");

  a_mark_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    mark_r <= cnt_r)
    else $error("unsafe mark beyond grant count");

endmodule

// File: src/banker_safety_checker_unit.sv
// ----------------------------------------------------------------------------
// banker_safety_checker_unit
// Banker's algorithm resource tracker with a safety check after every grant.
// ----------------------------------------------------------------------------
// Load free and load need items are written from the idle state and busy stays
// low. A restart sweeps all MAX_RESOURCES slots, copying the loaded free counts
// back. A grant walks the tables in memory one entry at a time: the grant
// itself reads a single free entry, the finish test and the release of the
// full need each scan one row of resource_count entries, then the safety check
// copies the free counts and walks every unfinished process's row, passing
// over the processes again while any finishes; a first grant to a process
// after restart also copies that process's full need into its remaining need.
// Once a grant has been found unsafe, later grants skip the walk. The result
// of a grant appears on the out_ ports, marked by out_valid for one cycle, and
// cannot be held off.
module banker_safety_checker_unit #(
  parameter int MAX_PROCESSES = bsc_pkg::DEF_MAX_PROCESSES,
  parameter int MAX_RESOURCES = bsc_pkg::DEF_MAX_RESOURCES,
  parameter int AMOUNT_WIDTH  = bsc_pkg::DEF_AMOUNT_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_opcode,
  input  logic [5:0]                     in_process_index,
  input  logic [5:0]                     in_resource_index,
  input  logic [15:0]                    in_amount,
  output logic                           out_valid,
  output logic                           out_safe,
  output logic [15:0]                    out_grant_number,
  output logic [15:0]                    out_first_unsafe,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bsc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import bsc_pkg::*;

  cfg_t cfg;

  bsc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bsc_ctrl #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .MAX_RESOURCES (MAX_RESOURCES),
    .AMOUNT_WIDTH  (AMOUNT_WIDTH)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .start            (start),
    .opcode           (in_opcode),
    .process_index    (in_process_index),
    .resource_index   (in_resource_index),
    .amount           (in_amount),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_safe         (out_safe),
    .out_grant_number (out_grant_number),
    .out_first_unsafe (out_first_unsafe)
  );

endmodule

// File: dv/banker_safety_checker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banker_safety_checker_unit_tb
// Self-checking bench for the banker safety checker: a directed table of
// loads, grants and restarts, then random phases over several process and
// resource counts, grants checked against typed table rows or an in-bench model.
// ----------------------------------------------------------------------------
module banker_safety_checker_unit_tb;
  import bsc_pkg::*;

  localparam int NPROC = DEF_MAX_PROCESSES;
  localparam int NRES = DEF_MAX_RESOURCES;
  localparam longint FREE_CEIL = (64'd1 << (DEF_AMOUNT_WIDTH + 8)) - 1;
  localparam longint REM_FLOOR = -(64'd1 << DEF_AMOUNT_WIDTH);
  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    logic        safe;
    logic [15:0] grant_number;
    logic [15:0] first_unsafe;
  } verdict_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  proc_idx;
    logic [5:0]  res_idx;
    logic [15:0] amount;
    logic        typed;
    verdict_t    want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_opcode = '0;
  logic [5:0] in_process_index = '0;
  logic [5:0] in_resource_index = '0;
  logic [15:0] in_amount = '0;
  logic out_valid, out_safe;
  logic [15:0] out_grant_number, out_first_unsafe;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  banker_safety_checker_unit DUT (
    .clk, .rst_n, .start, .busy, .in_opcode, .in_process_index, .in_resource_index,
    .in_amount, .out_valid, .out_safe, .out_grant_number, .out_first_unsafe,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // bench copy of the tracker state
  logic [CFG_W-1:0] proc_cfg = PROCESS_COUNT_RST;
  logic [CFG_W-1:0] res_cfg = RESOURCE_COUNT_RST;
  longint free_now [NRES];
  longint free_base [NRES];
  longint need_full [NPROC][NRES];
  longint need_left [NPROC][NRES];
  bit     proc_done [NPROC];
  int     grant_cnt;
  int     unsafe_at;
  bit     free_loaded [NRES];
  bit     need_loaded [NPROC][NRES];

  verdict_t pending [$];
  int  err_count = 0;
  int  stall_cycles = 0;
  bit  accepted_now;
  int  burst_left = 0;

  function automatic int eff_count(logic [CFG_W-1:0] v, int top);
    if (v == 0) return 1;
    return (v > top) ? top : int'(v);
  endfunction

  function automatic longint cap_free(longint v);
    return (v > FREE_CEIL) ? FREE_CEIL : v;
  endfunction

  function automatic bit all_can_finish(int np, int nr);
    longint work [NRES];
    bit fin [NPROC];
    bit moved, fits;
    for (int j = 0; j < NRES; j++) work[j] = free_now[j];
    for (int i = 0; i < NPROC; i++) fin[i] = proc_done[i];
    moved = 1;
    while (moved) begin
      moved = 0;
      for (int i = 0; i < np; i++) begin
        if (!fin[i]) begin
          fits = 1;
          for (int j = 0; j < nr; j++) if (need_left[i][j] > work[j]) fits = 0;
          if (fits) begin
            for (int j = 0; j < nr; j++)
              work[j] = cap_free(work[j] + need_full[i][j] - need_left[i][j]);
            fin[i] = 1;
            moved = 1;
          end
        end
      end
    end
    for (int i = 0; i < np; i++) if (!fin[i]) return 0;
    return 1;
  endfunction

  function automatic void take_unit(int p, int r, int np, int nr);
    bit met;
    if (p >= np || r >= nr) return;
    if (free_now[r] <= 0) begin
      if (unsafe_at == 0) unsafe_at = grant_cnt;
      return;
    end
    free_now[r]--;
    if (need_left[p][r] > REM_FLOOR) need_left[p][r]--;
    if (proc_done[p]) return;
    met = 1;
    for (int j = 0; j < nr; j++) if (need_left[p][j] > 0) met = 0;
    if (met) begin
      proc_done[p] = 1;
      for (int j = 0; j < nr; j++) free_now[j] = cap_free(free_now[j] + need_full[p][j]);
    end
  endfunction

  // updates the bench state; returns 1 when the item yields a verdict
  function automatic bit apply_item(logic [1:0] op, int p, int r, longint amt,
                                    output verdict_t v);
    int np, nr;
    np = eff_count(proc_cfg, NPROC);
    nr = eff_count(res_cfg, NRES);
    v = '0;
    case (op)
      OP_LOAD_FREE: begin
        free_base[r] = amt;
        free_now[r] = amt;
        free_loaded[r] = 1;
        return 0;
      end
      OP_LOAD_NEED: begin
        need_full[p][r] = amt;
        need_left[p][r] = amt;
        need_loaded[p][r] = 1;
        return 0;
      end
      OP_RESTART: begin
        for (int j = 0; j < NRES; j++) free_now[j] = free_base[j];
        for (int i = 0; i < NPROC; i++) begin
          proc_done[i] = 0;
          for (int j = 0; j < NRES; j++) need_left[i][j] = need_full[i][j];
        end
        grant_cnt = 0;
        unsafe_at = 0;
        return 0;
      end
      default: begin
        if (grant_cnt < 65535) grant_cnt++;
        if (unsafe_at == 0) begin
          take_unit(p, r, np, nr);
          if (unsafe_at == 0 && !all_can_finish(np, nr)) unsafe_at = grant_cnt;
        end
        v.safe = (unsafe_at == 0);
        v.grant_number = grant_cnt[15:0];
        v.first_unsafe = unsafe_at[15:0];
        return 1;
      end
    endcase
  endfunction

  task automatic send_item(step_row_t row);
    verdict_t v;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    burst_left--;
    in_opcode <= row.op;
    in_process_index <= row.proc_idx;
    in_resource_index <= row.res_idx;
    in_amount <= row.amount;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (apply_item(row.op, int'(row.proc_idx), int'(row.res_idx), longint'(row.amount), v))
      pending.push_back(row.typed ? row.want : v);
  endtask

  task automatic send_op(logic [1:0] op, int p, int r, int amt);
    step_row_t row;
    row = '0;
    row.op = op;
    row.proc_idx = 6'(p);
    row.res_idx = 6'(r);
    row.amount = 16'(amt);
    send_item(row);
  endtask

  // idle: no item in flight and no verdict outstanding
  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending.size() != 0 || busy);
    repeat (300) @(posedge clk);
  endtask

  task automatic cfg_write(logic reg_sel, logic [CFG_W-1:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {reg_sel, 2'b00};
    pwdata <= {25'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == REG_PROCESS_COUNT) proc_cfg = val;
    else res_cfg = val;
  endtask

  function automatic int pick_amount(int usual_top);
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                       : $urandom_range(0, usual_top);
  endfunction

  task automatic random_phase(logic [CFG_W-1:0] pc, logic [CFG_W-1:0] rc, int n_items);
    int np, nr, sel;
    wait_idle();
    cfg_write(REG_PROCESS_COUNT, pc);
    cfg_write(REG_RESOURCE_COUNT, rc);
    np = eff_count(pc, NPROC);
    nr = eff_count(rc, NRES);
    // every entry a grant can read gets a value first
    for (int j = 0; j < nr; j++)
      if (!free_loaded[j]) send_op(OP_LOAD_FREE, 0, j, $urandom_range(0, 8));
    for (int i = 0; i < np; i++)
      for (int j = 0; j < nr; j++)
        if (!need_loaded[i][j]) send_op(OP_LOAD_NEED, i, j, $urandom_range(0, 3));
    send_op(OP_RESTART, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
    for (int k = 0; k < n_items; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 10)
        send_op(OP_LOAD_FREE, $urandom_range(0, 63), $urandom_range(0, 63), pick_amount(8));
      else if (sel < 20)
        send_op(OP_LOAD_NEED, $urandom_range(0, 63), $urandom_range(0, 63), pick_amount(3));
      else if (sel < 30)
        send_op(OP_RESTART, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
      else if (sel < 36)
        send_op(OP_GRANT, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
      else
        send_op(OP_GRANT, $urandom_range(0, np - 1), $urandom_range(0, nr - 1), $urandom);
    end
  endtask

  // directed table, run with two processes and two resources
  step_row_t dir_rows [20] = '{
    '{OP_LOAD_FREE, 6'd0,  6'd0,  16'd1,     1'b0, '0},
    '{OP_LOAD_FREE, 6'd0,  6'd1,  16'hFFFF,  1'b0, '0},
    '{OP_LOAD_FREE, 6'd0,  6'd63, 16'hFFFF,  1'b0, '0},
    '{OP_LOAD_NEED, 6'd63, 6'd63, 16'd0,     1'b0, '0},
    '{OP_LOAD_NEED, 6'd0,  6'd0,  16'd1,     1'b0, '0},
    '{OP_LOAD_NEED, 6'd0,  6'd1,  16'd0,     1'b0, '0},
    '{OP_LOAD_NEED, 6'd1,  6'd0,  16'd1,     1'b0, '0},
    '{OP_LOAD_NEED, 6'd1,  6'd1,  16'd1,     1'b0, '0},
    '{OP_GRANT,     6'd0,  6'd0,  16'd0,     1'b1, '{1'b1, 16'd1, 16'd0}},
    '{OP_GRANT,     6'd5,  6'd0,  16'd0,     1'b1, '{1'b1, 16'd2, 16'd0}},
    '{OP_GRANT,     6'd1,  6'd0,  16'd0,     1'b0, '0},
    '{OP_GRANT,     6'd1,  6'd1,  16'd0,     1'b0, '0},
    '{OP_GRANT,     6'd1,  6'd1,  16'hFFFF,  1'b0, '0},
    '{OP_GRANT,     6'd0,  6'd0,  16'd0,     1'b0, '0},
    '{OP_GRANT,     6'd0,  6'd0,  16'd0,     1'b1, '{1'b0, 16'd7, 16'd7}},
    '{OP_GRANT,     6'd1,  6'd1,  16'd0,     1'b1, '{1'b0, 16'd8, 16'd7}},
    '{OP_RESTART,   6'd63, 6'd63, 16'hFFFF,  1'b0, '0},
    '{OP_GRANT,     6'd0,  6'd63, 16'd0,     1'b1, '{1'b1, 16'd1, 16'd0}},
    '{OP_LOAD_FREE, 6'd0,  6'd0,  16'd0,     1'b0, '0},
    '{OP_GRANT,     6'd0,  6'd0,  16'd0,     1'b1, '{1'b0, 16'd2, 16'd2}}
  };

  initial begin
    for (int j = 0; j < NRES; j++) begin
      free_now[j] = 0;
      free_base[j] = 0;
      free_loaded[j] = 0;
    end
    for (int i = 0; i < NPROC; i++) begin
      proc_done[i] = 0;
      for (int j = 0; j < NRES; j++) begin
        need_full[i][j] = 0;
        need_left[i][j] = 0;
        need_loaded[i][j] = 0;
      end
    end
    grant_cnt = 0;
    unsafe_at = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    cfg_write(REG_PROCESS_COUNT, 7'd2);
    cfg_write(REG_RESOURCE_COUNT, 7'd2);
    foreach (dir_rows[k]) send_item(dir_rows[k]);

    random_phase(7'd1, 7'd1, 8);
    random_phase(7'd3, 7'd2, 12);
    random_phase(7'd2, 7'd3, 12);
    random_phase(7'd4, 7'd4, 14);
    random_phase(7'd0, 7'd0, 5);
    random_phase(7'd65, 7'd1, 6);

    wait_idle();
    if (err_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // verdict checker
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_valid) begin
      if (pending.size() == 0) begin
        $error("verdict with none outstanding: grant_number %0d", out_grant_number);
        err_count++;
      end else begin
        exp_v = pending.pop_front();
        if (out_safe !== exp_v.safe) begin
          $error("safe: expected %0d, actual %0d", exp_v.safe, out_safe);
          err_count++;
        end
        if (out_grant_number !== exp_v.grant_number) begin
          $error("grant_number: expected %0d, actual %0d",
                 exp_v.grant_number, out_grant_number);
          err_count++;
        end
        if (out_first_unsafe !== exp_v.first_unsafe) begin
          $error("first_unsafe: expected %0d, actual %0d",
                 exp_v.first_unsafe, out_first_unsafe);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no item and no verdict moving
  always @(posedge clk) begin
    accepted_now = rst_n && ((start && !busy) || out_valid);
    if (accepted_now) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

// File: files.f
src/bsc_pkg.sv
src/bsc_ram.sv
src/bsc_cfg.sv
src/bsc_ctrl.sv
src/banker_safety_checker_unit.sv
dv/banker_safety_checker_unit_tb.sv
